FILE: sv/evfifo_pkg.sv
`default_nettype none

package evfifo_pkg;

    localparam int DEPTH_DEFAULT       = 16;
    localparam int EVENT_WIDTH_DEFAULT = 32;

    localparam int DATA_W   = 32;
    localparam int STAT_W   = 32;
    localparam int STATUS_W = 3;
    localparam int POLICY_W = 2;

    // full policy codes
    localparam logic [POLICY_W-1:0] POL_DROP_OLDEST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_REJECT      = 2'd1;
    localparam logic [POLICY_W-1:0] POL_FAULT       = 2'd2;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_PUSHED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PUSHED_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAULT       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_POPPED      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

    typedef struct packed {
        logic [STAT_W-1:0] pushed;
        logic [STAT_W-1:0] popped;
        logic [STAT_W-1:0] overflow;
        logic [STAT_W-1:0] rejected;
        logic [STAT_W-1:0] fault;
        logic [STAT_W-1:0] dropped;
    } stats_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   popped_data;
        stats_t              stats;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/event_fifo_with_full_policy.sv
`default_nettype none

// Event FIFO with a full policy. Takes one push or pop transfer per clock, unless
// m_ready holds the output, and returns one result per transfer (input register,
// then result register); sustained rate is one item per cycle while not stalled,
// set by updating the pointers, occupancy and statistics counters at once. The
// head of the store is prefetched into a read register so back-to-back pops
// run at full rate. full_policy (0 drop oldest, 1 reject newest, 2 signal
// fault, 3 as drop oldest) should only be written while no transfer is in
// flight. All statistics wrap at 32 bits and clear at reset.
module event_fifo_with_full_policy #(
    parameter int DEPTH       = evfifo_pkg::DEPTH_DEFAULT,
    parameter int EVENT_WIDTH = evfifo_pkg::EVENT_WIDTH_DEFAULT,
    localparam int PTR_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [evfifo_pkg::POLICY_W-1:0] cfg_wr_data,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_op,
    input  wire logic [evfifo_pkg::DATA_W-1:0]   s_event_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [evfifo_pkg::STATUS_W-1:0]      m_status,
    output logic [evfifo_pkg::DATA_W-1:0]        m_popped_data,
    output logic [CNT_W-1:0]                     m_occupancy,
    output logic [evfifo_pkg::STAT_W-1:0]        m_pushed_total,
    output logic [evfifo_pkg::STAT_W-1:0]        m_popped_total,
    output logic [evfifo_pkg::STAT_W-1:0]        m_overflow_total,
    output logic [evfifo_pkg::STAT_W-1:0]        m_rejected_total,
    output logic [evfifo_pkg::STAT_W-1:0]        m_fault_total,
    output logic [evfifo_pkg::STAT_W-1:0]        m_dropped_total
);

    logic [evfifo_pkg::POLICY_W-1:0] full_policy_reg;

    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [evfifo_pkg::DATA_W-1:0] in_data_reg;

    logic                 m_valid_reg;
    evfifo_pkg::result_t  m_result_reg;
    logic [CNT_W-1:0]     m_occupancy_reg;

    logic out_adv, in_fire;

    logic                   wr_en;
    logic [PTR_W-1:0]       wr_addr;
    logic [EVENT_WIDTH-1:0] wr_data;
    logic [PTR_W-1:0]       rd_addr;
    logic [EVENT_WIDTH-1:0] rd_data;
    evfifo_pkg::result_t    result;
    logic [CNT_W-1:0]       occupancy;

    assign out_adv = !m_valid_reg || m_ready;
    assign in_fire = in_valid_reg && out_adv;
    assign s_ready = !in_valid_reg || out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_policy_reg <= evfifo_pkg::POL_DROP_OLDEST;
        end else if (cfg_wr_en) begin
            full_policy_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg   <= s_op;
            in_data_reg <= s_event_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_result_reg    <= result;
            m_occupancy_reg <= occupancy;
        end
    end

    evfifo_core #(
        .DEPTH       (DEPTH),
        .EVENT_WIDTH (EVENT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (in_fire),
        .op          (in_op_reg),
        .event_data  (in_data_reg),
        .full_policy (full_policy_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .result      (result),
        .occupancy   (occupancy)
    );

    evfifo_store #(
        .DEPTH       (DEPTH),
        .EVENT_WIDTH (EVENT_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_valid          = m_valid_reg;
    assign m_status         = m_result_reg.status;
    assign m_popped_data    = m_result_reg.popped_data;
    assign m_occupancy      = m_occupancy_reg;
    assign m_pushed_total   = m_result_reg.stats.pushed;
    assign m_popped_total   = m_result_reg.stats.popped;
    assign m_overflow_total = m_result_reg.stats.overflow;
    assign m_rejected_total = m_result_reg.stats.rejected;
    assign m_fault_total    = m_result_reg.stats.fault;
    assign m_dropped_total  = m_result_reg.stats.dropped;

endmodule

`default_nettype wire

FILE: sv/evfifo_store.sv
`default_nettype none

module evfifo_store #(
    parameter int DEPTH       = evfifo_pkg::DEPTH_DEFAULT,
    parameter int EVENT_WIDTH = evfifo_pkg::EVENT_WIDTH_DEFAULT,
    localparam int PTR_W      = $clog2(DEPTH)
) (
    input  wire logic                   aclk,
    input  wire logic                   wr_en,
    input  wire logic [PTR_W-1:0]       wr_addr,
    input  wire logic [EVENT_WIDTH-1:0] wr_data,
    input  wire logic [PTR_W-1:0]       rd_addr,
    output logic      [EVENT_WIDTH-1:0] rd_data
);

    logic [EVENT_WIDTH-1:0] mem [DEPTH];
    logic [EVENT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // write-first: a word pushed into an empty FIFO is visible at once
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: sv/evfifo_core.sv
`default_nettype none

module evfifo_core #(
    parameter int DEPTH       = evfifo_pkg::DEPTH_DEFAULT,
    parameter int EVENT_WIDTH = evfifo_pkg::EVENT_WIDTH_DEFAULT,
    localparam int PTR_W      = $clog2(DEPTH),
    localparam int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                fire,
    input  wire logic                                op,
    input  wire logic [evfifo_pkg::DATA_W-1:0]       event_data,
    input  wire logic [evfifo_pkg::POLICY_W-1:0]     full_policy,
    output logic                                     wr_en,
    output logic      [PTR_W-1:0]                    wr_addr,
    output logic      [EVENT_WIDTH-1:0]              wr_data,
    output logic      [PTR_W-1:0]                    rd_addr,
    input  wire logic [EVENT_WIDTH-1:0]              rd_data,
    output evfifo_pkg::result_t                      result,
    output logic      [CNT_W-1:0]                    occupancy
);

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    evfifo_pkg::stats_t stats_reg, stats_next;

    logic full, empty, is_push, do_store, drop_old, do_pop, rd_adv;
    logic [evfifo_pkg::STATUS_W-1:0] status;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        full     = (count_reg == CNT_W'(DEPTH));
        empty    = (count_reg == '0);
        is_push  = (op == evfifo_pkg::OP_PUSH);
        do_store = 1'b0;
        drop_old = 1'b0;
        do_pop   = 1'b0;
        status   = evfifo_pkg::ST_PUSHED;

        if (is_push) begin
            if (!full) begin
                do_store = 1'b1;
                status   = evfifo_pkg::ST_PUSHED;
            end else begin
                case (full_policy)
                    evfifo_pkg::POL_REJECT: status = evfifo_pkg::ST_REJECTED;
                    evfifo_pkg::POL_FAULT:  status = evfifo_pkg::ST_FAULT;
                    default: begin
                        // unused policy code behaves as drop oldest
                        do_store = 1'b1;
                        drop_old = 1'b1;
                        status   = evfifo_pkg::ST_PUSHED_DROP;
                    end
                endcase
            end
        end else begin
            if (empty) begin
                status = evfifo_pkg::ST_EMPTY;
            end else begin
                do_pop = 1'b1;
                status = evfifo_pkg::ST_POPPED;
            end
        end

        rd_adv = drop_old || do_pop;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (fire) begin
            if (do_store) begin
                wr_ptr_next = ptr_inc(wr_ptr_reg);
            end
            if (rd_adv) begin
                rd_ptr_next = ptr_inc(rd_ptr_reg);
            end
            if (do_store && !drop_old) begin
                count_next = count_reg + 1'b1;
            end else if (do_pop) begin
                count_next = count_reg - 1'b1;
            end
        end

        stats_next = stats_reg;
        if (fire) begin
            if (do_store) begin
                stats_next.pushed = stats_reg.pushed + 1'b1;
            end
            if (do_pop) begin
                stats_next.popped = stats_reg.popped + 1'b1;
            end
            if (is_push && full) begin
                stats_next.overflow = stats_reg.overflow + 1'b1;
            end
            if (status == evfifo_pkg::ST_REJECTED) begin
                stats_next.rejected = stats_reg.rejected + 1'b1;
            end
            if (status == evfifo_pkg::ST_FAULT) begin
                stats_next.fault = stats_reg.fault + 1'b1;
            end
            if (drop_old) begin
                stats_next.dropped = stats_reg.dropped + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            stats_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            stats_reg  <= stats_next;
        end
    end

    assign wr_en   = fire && do_store;
    assign wr_addr = wr_ptr_reg;
    assign wr_data = EVENT_WIDTH'(event_data);
    // prefetch the word that will be at the head next cycle
    assign rd_addr = rd_ptr_next;

    assign result.status      = status;
    assign result.popped_data = do_pop ? evfifo_pkg::DATA_W'(rd_data) : '0;
    assign result.stats       = stats_next;
    assign occupancy          = count_next;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ while empty");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ while full");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && (op == evfifo_pkg::OP_POP) && (count_reg != '0))
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not reduce occupancy");
`endif

endmodule

`default_nettype wire
